// ===== rtl/slot_free_list_allocator_core_macros.svh =====
// ----------------------------------------------------------------------------
// Slot allocator assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SLOT_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH
`define SLOT_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define SFLA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("slot allocator check failed");

// next-cycle implication
`define SFLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("slot allocator check failed");

`endif

// ===== rtl/sfla_pkg.sv =====
// ----------------------------------------------------------------------------
// Slot allocator package
// Shared widths, command and status codes, and the decision record passed
// from the decode logic to the state registers.
// ----------------------------------------------------------------------------
package sfla_pkg;

    localparam int IDX_W    = 8;
    localparam int CNT_W    = 9;
    localparam int MAX_POOL = 256;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_RANGE     = 2'd2,
        ST_DOUBLE    = 2'd3
    } t_status;

    typedef struct packed {
        logic             pop;    // allocate from the head of the freed list
        logic             grab;   // allocate a never-used slot from the counter
        logic             push;   // accepted free, becomes the new list head
        logic [IDX_W-1:0] given;
        t_status          status;
    } t_decision;

endpackage

// ===== rtl/sfla_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sfla_decide.sv =====
// ----------------------------------------------------------------------------
// Slot allocator command decode
// Picks the source of an allocation or checks a free against range and the
// slot's free flag, and forms the result fields.
// ----------------------------------------------------------------------------
module sfla_decide #(
    parameter int POOL = 256
) (
    input  logic                        i_command,
    input  logic [sfla_pkg::IDX_W-1:0]  i_index,
    input  logic [sfla_pkg::IDX_W-1:0]  i_head,
    input  logic [sfla_pkg::CNT_W-1:0]  i_fresh,
    input  logic                        i_flag,
    output sfla_pkg::t_decision         o_dec
);

    localparam logic [sfla_pkg::CNT_W-1:0] POOL_LIM = sfla_pkg::CNT_W'(POOL);

    always_comb begin
        o_dec        = '0;
        o_dec.status = sfla_pkg::ST_OK;
        if (i_command == sfla_pkg::CMD_ALLOC) begin
            if (i_head != '0) begin
                o_dec.pop   = 1'b1;
                o_dec.given = i_head;
            end else if (i_fresh < POOL_LIM) begin
                o_dec.grab  = 1'b1;
                o_dec.given = i_fresh[sfla_pkg::IDX_W-1:0];
            end else begin
                o_dec.status = sfla_pkg::ST_EXHAUSTED;
            end
        end else begin
            if (i_index == '0 || {1'b0, i_index} >= POOL_LIM) begin
                o_dec.status = sfla_pkg::ST_RANGE;
            end else if (i_flag) begin
                o_dec.status = sfla_pkg::ST_DOUBLE;
            end else begin
                o_dec.push = 1'b1;
            end
        end
    end

endmodule

// ===== rtl/slot_free_list_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Slot free-list allocator
// Hands out slot indices 1..POOL-1, freed ones first, reused last-in first-out,
// then fresh ones in order, and rejects bad or repeated frees.
// ----------------------------------------------------------------------------
// One allocate or free command is taken every cycle while busy is low; busy is
// high while reset is held and until the ready register is set after reset is
// released. The command passes through the input register and then the result
// register, so o_strobe marks o_given_index/o_status for one cycle. The result
// must be taken at the edge that ends that cycle: there is no back-pressure.
// Throughput is set by the one link read per allocation from the link RAM;
// the link of the current list head is kept prefetched (or bypassed on a
// free) so that back-to-back allocations need no wait. Pool size is
// min(SLOTS, 256); no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "slot_free_list_allocator_core_macros.svh"

module slot_free_list_allocator_core #(
    parameter int SLOTS = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_command,
    input  logic [sfla_pkg::IDX_W-1:0] i_free_index,
    output logic                       o_strobe,
    output logic [sfla_pkg::IDX_W-1:0] o_given_index,
    output logic [1:0]                 o_status
);

    localparam int POOL = (SLOTS < sfla_pkg::MAX_POOL) ? SLOTS : sfla_pkg::MAX_POOL;
    localparam int AW   = $clog2(POOL);

    // input register
    logic                       r_ready;
    logic                       r_a_valid;
    logic                       r_a_command;
    logic [sfla_pkg::IDX_W-1:0] r_a_index;

    // allocator state
    logic [POOL-1:0]            r_free_flags, n_free_flags;
    logic [sfla_pkg::IDX_W-1:0] r_head, n_head;
    logic [sfla_pkg::CNT_W-1:0] r_fresh, n_fresh;
    logic                       r_link_sel, n_link_sel;
    logic [sfla_pkg::IDX_W-1:0] r_link_byp, n_link_byp;

    // result register
    logic                       r_strobe;
    logic [sfla_pkg::IDX_W-1:0] r_given;
    sfla_pkg::t_status          r_status;

    logic                       w_accept;
    logic                       w_flag;
    logic [sfla_pkg::IDX_W-1:0] w_head_link;
    logic [sfla_pkg::IDX_W-1:0] w_rdata;
    logic                       w_we;
    sfla_pkg::t_decision        w_dec;

    assign busy     = !r_ready;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready   <= 1'b0;
            r_a_valid <= 1'b0;
        end else begin
            r_ready   <= 1'b1;
            r_a_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_command <= i_command;
            r_a_index   <= i_free_index;
        end
    end

    assign w_flag      = r_free_flags[r_a_index[AW-1:0]];
    assign w_head_link = r_link_sel ? w_rdata : r_link_byp;

    sfla_decide #(
        .POOL (POOL)
    ) u_decide (
        .i_command (r_a_command),
        .i_index   (r_a_index),
        .i_head    (r_head),
        .i_fresh   (r_fresh),
        .i_flag    (w_flag),
        .o_dec     (w_dec)
    );

    always_comb begin
        n_free_flags = r_free_flags;
        n_head       = r_head;
        n_fresh      = r_fresh;
        n_link_sel   = r_link_sel;
        n_link_byp   = r_link_byp;
        w_we         = 1'b0;
        if (r_a_valid) begin
            if (w_dec.pop) begin
                n_free_flags[r_head[AW-1:0]] = 1'b0;
                n_head                       = w_head_link;
                // link of the new head is read from the RAM this cycle
                n_link_sel                   = 1'b1;
            end
            if (w_dec.grab) begin
                n_free_flags[r_fresh[AW-1:0]] = 1'b0;
                n_fresh                       = r_fresh + sfla_pkg::CNT_W'(1);
            end
            if (w_dec.push) begin
                n_free_flags[r_a_index[AW-1:0]] = 1'b1;
                n_head                          = r_a_index;
                // new head's link is the old head; RAM read would collide with the write
                n_link_byp                      = r_head;
                n_link_sel                      = 1'b0;
                w_we                            = 1'b1;
            end
        end
    end

    sfla_ram #(
        .WIDTH (sfla_pkg::IDX_W),
        .DEPTH (POOL)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_a_index[AW-1:0]),
        .i_wdata (r_head),
        .i_raddr (n_head[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_flags <= {{(POOL-1){1'b1}}, 1'b0};
            r_head       <= '0;
            r_fresh      <= sfla_pkg::CNT_W'(1);
            r_link_sel   <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_free_flags <= n_free_flags;
            r_head       <= n_head;
            r_fresh      <= n_fresh;
            r_link_sel   <= n_link_sel;
            r_strobe     <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_link_byp <= n_link_byp;
        if (r_a_valid) begin
            r_given  <= w_dec.given;
            r_status <= w_dec.status;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_given_index = r_given;
    assign o_status      = r_status;

    `SFLA_ASSERT_SAME(a_given_ok, i_clk, i_rst_n, r_strobe && |r_given, r_status == sfla_pkg::ST_OK)
    `SFLA_ASSERT_SAME(a_head_free, i_clk, i_rst_n, r_head != '0, r_free_flags[r_head[AW-1:0]])
    `SFLA_ASSERT_SAME(a_fresh_cap, i_clk, i_rst_n, 1'b1, r_fresh <= sfla_pkg::CNT_W'(POOL))
    `SFLA_ASSERT_NEXT(a_result_lat, i_clk, i_rst_n, start && !busy, ##1 o_strobe)

endmodule
